// ===== sv/string_literal_unescape_defines.svh =====
// Assertion macros used by the checker file of the string literal unescaper.
// No dependencies; include by bare file name.
`ifndef STRING_LITERAL_UNESCAPE_DEFINES_SVH
`define STRING_LITERAL_UNESCAPE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SLU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slu assertion failed");

// Next-cycle implication, off while reset is high.
`define SLU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slu assertion failed");

// Next-cycle implication that also holds through reset.
`define SLU_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slu assertion failed");

`endif

// ===== sv/slu_pkg.sv =====
// Shared types, character codes and the escape table of the string literal unescaper.
// No dependencies.
`default_nettype none

package slu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BODY  = 2'd1,
    PH_QUOTE = 2'd2,
    PH_ESC   = 2'd3
  } slu_phase_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESCAPE = 8'h1B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UPPERE = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWERE = 8'h65;
  localparam logic [7:0] CH_LOWERN = 8'h6E;
  localparam logic [7:0] CH_LOWERR = 8'h72;
  localparam logic [7:0] CH_LOWERT = 8'h74;

  // Register index of escapes_enabled.
  localparam logic REG_ESC_EN = 1'b0;

  typedef struct packed {
    logic [7:0] out_char;
    logic       literal_end;
    logic       bad_escape;
    logic       overflow;
  } slu_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } slu_esc_t;

  // Character that follows a backslash, mapped to what it stands for.
  function automatic slu_esc_t slu_escape_map(input logic [7:0] b);
    slu_esc_t r;
    r.bad = 1'b0;
    case (b)
      CH_QUOTE:             r.ch = CH_QUOTE;
      CH_UPPERE, CH_LOWERE: r.ch = CH_ESCAPE;
      CH_LOWERN:            r.ch = CH_LF;
      CH_LOWERR:            r.ch = CH_CR;
      CH_LOWERT:            r.ch = CH_TAB;
      CH_BSLASH:            r.ch = CH_BSLASH;
      default: begin
        r.ch  = b;
        r.bad = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/slu_in_if.sv =====
// Input byte channel of the string literal unescaper.
// Stand-alone interface; no dependencies.
`default_nettype none

interface slu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_mark;

  modport source (output valid, output in_byte, output start_mark, input ready);
  modport sink (input valid, input in_byte, input start_mark, output ready);
endinterface

`default_nettype wire

// ===== sv/slu_out_if.sv =====
// Result channel of the string literal unescaper.
// Stand-alone interface; no dependencies.
`default_nettype none

interface slu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       literal_end;
  logic       bad_escape;
  logic       overflow;

  modport source (output valid, output out_char, output literal_end,
                  output bad_escape, output overflow, input ready);
  modport sink (input valid, input out_char, input literal_end,
                input bad_escape, input overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/slu_apb.sv =====
// APB register block: holds escapes_enabled and answers reads.
// Depends on slu_pkg.
`default_nettype none

module slu_apb
  import slu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             esc_en
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ESC_EN);

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_en <= 1'b1;
    end else if (wr_en) begin
      esc_en <= pwdata[0];
    end
  end

  // Byte-lane bits of paddr do not select a register.
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ESC_EN: prdata[0] = esc_en;
      default:    prdata    = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/slu_decode.sv =====
// Per-byte decode: scan phase and length count in, next state and optional result out.
// Depends on slu_pkg.
`default_nettype none

module slu_decode
  import slu_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire slu_phase_t                   phase,
  input  wire logic [$clog2(MAX_LEN)-1:0]   count,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         start_mark,
  input  wire logic                         esc_en,
  output slu_phase_t                        phase_next,
  output logic [$clog2(MAX_LEN)-1:0]        count_next,
  output logic                              has_result,
  output slu_result_t                       result
);

  localparam int CntW = $clog2(MAX_LEN);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LEN - 1);

  slu_esc_t   esc;
  logic       emit;
  logic [7:0] emit_ch;
  logic       emit_bad;
  logic       room;

  assign esc  = slu_escape_map(in_byte);
  assign room = count < CntMax;

  // Next scan phase.
  always_comb begin
    phase_next = phase;
    if (start_mark) begin
      phase_next = PH_BODY;
    end else begin
      unique case (phase)
        PH_IDLE:  phase_next = PH_IDLE;
        PH_BODY: begin
          if (in_byte == CH_NUL) begin
            phase_next = PH_IDLE;
          end else if (in_byte == CH_QUOTE) begin
            phase_next = PH_QUOTE;
          end else if (esc_en && in_byte == CH_BSLASH) begin
            phase_next = PH_ESC;
          end
        end
        PH_QUOTE: phase_next = (in_byte == CH_QUOTE) ? PH_BODY : PH_IDLE;
        PH_ESC:   phase_next = (in_byte == CH_NUL) ? PH_IDLE : PH_BODY;
        default:  phase_next = PH_IDLE;
      endcase
    end
  end

  // Result and character emission.
  always_comb begin
    emit       = 1'b0;
    emit_ch    = in_byte;
    emit_bad   = 1'b0;
    has_result = 1'b0;
    result     = '0;
    if (!start_mark) begin
      unique case (phase)
        PH_IDLE: ;
        PH_BODY: begin
          if (in_byte == CH_NUL) begin
            has_result         = 1'b1;
            result.literal_end = 1'b1;
          end else if (in_byte != CH_QUOTE && !(esc_en && in_byte == CH_BSLASH)) begin
            emit = 1'b1;
          end
        end
        PH_QUOTE: begin
          if (in_byte == CH_QUOTE) begin
            emit = 1'b1;
          end else begin
            has_result         = 1'b1;
            result.literal_end = 1'b1;
          end
        end
        PH_ESC: begin
          if (in_byte == CH_NUL) begin
            has_result         = 1'b1;
            result.literal_end = 1'b1;
          end else begin
            emit     = 1'b1;
            emit_ch  = esc.ch;
            emit_bad = esc.bad;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      has_result        = 1'b1;
      result.bad_escape = emit_bad;
      result.overflow   = !room;
      result.out_char   = room ? emit_ch : CH_NUL;
    end
  end

  always_comb begin
    count_next = count;
    if (start_mark) begin
      count_next = '0;
    end else if (emit && room) begin
      count_next = count + CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/string_literal_unescape.sv =====
// Top level of the string literal unescaper: input register, decode, result register.
// Depends on slu_pkg, slu_in_if, slu_out_if, slu_apb and slu_decode.
//
//  Channel  Dir  Payload                                          Beat
//  in_ch    in   in_byte[7:0], start_mark                         valid && ready
//  out_ch   out  out_char[7:0], literal_end, bad_escape, overflow valid && ready
//  APB      in   escapes_enabled at byte address 0                psel/penable/pwrite
//
// One byte per cycle sustained while out_ch.ready holds; input register, then result register.
// The only loop is the phase/count update in the decode stage, one step per advancing cycle.
// Reset clears the phase to idle, the count to zero and escapes_enabled to 1.
// A stalled result holds in the output register while one more beat waits in
// the input register; in_ch.ready drops only when both are full.
`default_nettype none

module string_literal_unescape
  import slu_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  slu_in_if.sink           in_ch,
  slu_out_if.source        out_ch
);

  localparam int CntW = $clog2(MAX_LEN);

  logic              esc_en;
  logic              inq_valid;
  logic [7:0]        inq_byte;
  logic              inq_start;
  slu_phase_t        phase;
  slu_phase_t        phase_next;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic              has_result;
  slu_result_t       result;
  logic              out_valid;
  slu_result_t       out_data;
  logic              advance;

  slu_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .esc_en  (esc_en)
  );

  slu_decode #(.MAX_LEN(MAX_LEN)) u_decode (
    .phase      (phase),
    .count      (count),
    .in_byte    (inq_byte),
    .start_mark (inq_start),
    .esc_en     (esc_en),
    .phase_next (phase_next),
    .count_next (count_next),
    .has_result (has_result),
    .result     (result)
  );

  // Move the held byte on whenever the result register is free or draining.
  assign advance     = inq_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_IDLE;
      count     <= '0;
    end else begin
      if (in_ch.ready) begin
        inq_valid <= in_ch.valid;
      end
      if (advance) begin
        phase     <= phase_next;
        count     <= count_next;
        out_valid <= has_result;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inq_byte  <= in_ch.in_byte;
      inq_start <= in_ch.start_mark;
    end
    if (advance && has_result) begin
      out_data <= result;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_char    = out_data.out_char;
  assign out_ch.literal_end = out_data.literal_end;
  assign out_ch.bad_escape  = out_data.bad_escape;
  assign out_ch.overflow    = out_data.overflow;

endmodule

`default_nettype wire

// ===== sv/slu_checker.sv =====
// Port-level checker for the string literal unescaper, bound to the top level.
// Depends on string_literal_unescape_defines.svh and the top level's ports.
`default_nettype none
`include "string_literal_unescape_defines.svh"

module slu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       literal_end,
  input wire logic       bad_escape,
  input wire logic       overflow
);

  // Hold a stalled result and its payload.
  `SLU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SLU_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_char) && $stable(literal_end) && $stable(bad_escape) && $stable(overflow))
  // A draining output always frees the input side.
  `SLU_ASSERT_IMP(a_ready_path, clk, rst, out_ready, in_ready)
  // Drop any result while in reset.
  `SLU_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind string_literal_unescape slu_checker u_slu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .literal_end (out_ch.literal_end),
  .bad_escape  (out_ch.bad_escape),
  .overflow    (out_ch.overflow)
);

`default_nettype wire
